FILE: design/svtlp_pkg.sv
`default_nettype none
package svtlp_pkg;

   localparam int CHAR_W = 8;
   localparam int ID_W   = 32;
   localparam int TYPE_W = 2;
   localparam int STAT_W = 2;
   localparam int KW_LEN = 12;
   localparam int KW_IDX_W = $clog2(KW_LEN + 1);

   // Result queue; the depth must be a power of two so that the pointers wrap.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   localparam logic [STAT_W-1:0] ST_ACCEPTED  = 2'd0;
   localparam logic [STAT_W-1:0] ST_SYNTAX    = 2'd1;
   localparam logic [STAT_W-1:0] ST_TYPE_OOR  = 2'd2;
   localparam logic [STAT_W-1:0] ST_ID_OVFL   = 2'd3;

   localparam logic KIND_NAME    = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   localparam logic [CHAR_W-1:0] KW_TEXT [KW_LEN] = '{
      "S", "I", "G", "_", "V", "A", "L", "T", "Y", "P", "E", "_"
   };

   localparam logic [CHAR_W-1:0] CH_MINUS = "-";
   localparam logic [CHAR_W-1:0] CH_SEMI  = ";";
   localparam logic [CHAR_W-1:0] CH_UNDER = "_";
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [TYPE_W-1:0] TYPE_MAX = 2'd2;
   localparam logic [TYPE_W-1:0] TYPE_SAT = 2'd3;

   typedef struct packed {
      logic                     kind;
      logic [CHAR_W-1:0]        name_char;
      logic signed [ID_W-1:0]   msg_id;
      logic [TYPE_W-1:0]        value_type;
      logic [STAT_W-1:0]        status;
      logic                     last_of_run;
   } rsp_item_type;

   typedef struct packed {
      logic         name_valid;
      logic         verdict_valid;
      rsp_item_type name_res;
      rsp_item_type verdict_res;
   } push_type;

   function automatic logic is_ws(input logic [CHAR_W-1:0] c);
      return (c == 8'h20) || (c == 8'h0A) || (c == 8'h0D) || (c == 8'h09) ||
             (c == 8'h0B) || (c == 8'h0C);
   endfunction

   function automatic logic is_dig(input logic [CHAR_W-1:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_ident(input logic [CHAR_W-1:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
             is_dig(c) || (c == CH_UNDER);
   endfunction

endpackage
`default_nettype wire

FILE: design/svtlp_req_if.sv
`default_nettype none
interface svtlp_req_if import svtlp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              end_of_text;

   modport source (output valid, output char_code, output end_of_text, input ready);
   modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface
`default_nettype wire

FILE: design/svtlp_rsp_if.sv
`default_nettype none
interface svtlp_rsp_if import svtlp_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   kind;
   logic [CHAR_W-1:0]      name_char;
   logic signed [ID_W-1:0] msg_id;
   logic [TYPE_W-1:0]      value_type;
   logic [STAT_W-1:0]      status;
   logic                   last_of_run;

   modport source (output valid, output kind, output name_char, output msg_id,
                   output value_type, output status, output last_of_run, input ready);
   modport sink (input valid, input kind, input name_char, input msg_id,
                 input value_type, input status, input last_of_run, output ready);
endinterface
`default_nettype wire

FILE: design/svtlp_core.sv
`default_nettype none
module svtlp_core import svtlp_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [CHAR_W-1:0] char_code,
   input  wire logic              end_of_text,
   output push_type               push
);

   localparam logic [3:0] PH_LEAD       = 4'd0;
   localparam logic [3:0] PH_KEY        = 4'd1;
   localparam logic [3:0] PH_ID_WS      = 4'd2;
   localparam logic [3:0] PH_ID_SIGN    = 4'd3;
   localparam logic [3:0] PH_ID_DIG     = 4'd4;
   localparam logic [3:0] PH_NAME_WS    = 4'd5;
   localparam logic [3:0] PH_NAME       = 4'd6;
   localparam logic [3:0] PH_TYPE_WS    = 4'd7;
   localparam logic [3:0] PH_TYPE       = 4'd8;
   localparam logic [3:0] PH_SEMI_WS    = 4'd9;
   localparam logic [3:0] PH_AFTER_SEMI = 4'd10;
   localparam logic [3:0] PH_CR         = 4'd11;
   localparam logic [3:0] PH_DONE       = 4'd12;

   logic [3:0]          phase_ff, phase_in, ph;
   logic [KW_IDX_W-1:0] kw_idx_ff, kw_idx_in;
   logic                neg_ff, neg_in;
   logic [ID_W-1:0]     mag_ff, mag_in;
   logic                ovf_ff, ovf_in;
   logic [TYPE_W-1:0]   type_ff, type_in;
   logic [STAT_W-1:0]   stat_ff, stat_in;

   logic [3:0]          digit;
   logic [ID_W+3:0]     id_prod;
   logic [ID_W+3:0]     id_limit;
   logic                id_too_big;
   logic                name_hit;
   logic [ID_W-1:0]     verdict_id;

   assign digit    = char_code[3:0] - 4'd0;
   // mag * 10 + digit, built from shifts so no multiplier is needed.
   assign id_prod  = {1'b0, mag_ff, 3'b000} + {3'b000, mag_ff, 1'b0} +
                     {{(ID_W){1'b0}}, digit};
   assign id_limit = {4'b0000, 1'b0, {(ID_W-1){1'b1}}} + {{(ID_W+3){1'b0}}, neg_ff};
   assign id_too_big = id_prod > id_limit;

   always_comb begin
      phase_in  = phase_ff;
      kw_idx_in = kw_idx_ff;
      neg_in    = neg_ff;
      mag_in    = mag_ff;
      ovf_in    = ovf_ff;
      type_in   = type_ff;
      stat_in   = stat_ff;
      name_hit  = 1'b0;

      ph = phase_ff;
      if ((ph == PH_LEAD) && !is_ws(char_code)) begin
         ph = PH_KEY;
      end
      phase_in = ph;

      unique case (ph)
         PH_LEAD: begin
         end
         PH_KEY: begin
            if ((kw_idx_ff < KW_IDX_W'(KW_LEN)) &&
                (char_code == KW_TEXT[kw_idx_ff])) begin
               kw_idx_in = kw_idx_ff + 1'b1;
               if (kw_idx_ff == KW_IDX_W'(KW_LEN - 1)) begin
                  phase_in = PH_ID_WS;
               end
            end else begin
               stat_in  = ST_SYNTAX;
               phase_in = PH_DONE;
            end
         end
         PH_ID_WS, PH_ID_SIGN: begin
            if ((ph == PH_ID_WS) && is_ws(char_code)) begin
            end else if ((ph == PH_ID_WS) && (char_code == CH_MINUS)) begin
               neg_in   = 1'b1;
               phase_in = PH_ID_SIGN;
            end else if (is_dig(char_code)) begin
               if (id_too_big) begin
                  ovf_in = 1'b1;
               end else begin
                  mag_in = id_prod[ID_W-1:0];
               end
               phase_in = PH_ID_DIG;
            end else begin
               stat_in  = ST_SYNTAX;
               phase_in = PH_DONE;
            end
         end
         PH_ID_DIG: begin
            if (is_dig(char_code)) begin
               // Once overflowed, further digits are swallowed.
               if (!ovf_ff) begin
                  if (id_too_big) begin
                     ovf_in = 1'b1;
                  end else begin
                     mag_in = id_prod[ID_W-1:0];
                  end
               end
            end else if (ovf_ff) begin
               stat_in  = ST_ID_OVFL;
               phase_in = PH_DONE;
            end else if (is_ws(char_code)) begin
               phase_in = PH_NAME_WS;
            end else if (is_ident(char_code)) begin
               name_hit = 1'b1;
               phase_in = PH_NAME;
            end else begin
               stat_in  = ST_SYNTAX;
               phase_in = PH_DONE;
            end
         end
         PH_NAME_WS: begin
            if (is_ws(char_code)) begin
            end else if (is_ident(char_code)) begin
               name_hit = 1'b1;
               phase_in = PH_NAME;
            end else begin
               stat_in  = ST_SYNTAX;
               phase_in = PH_DONE;
            end
         end
         PH_NAME: begin
            if (is_ident(char_code)) begin
               name_hit = 1'b1;
            end else if (is_ws(char_code)) begin
               phase_in = PH_TYPE_WS;
            end else begin
               stat_in  = ST_SYNTAX;
               phase_in = PH_DONE;
            end
         end
         PH_TYPE_WS, PH_TYPE: begin
            if (is_dig(char_code)) begin
               // Any second digit after a non-zero one already exceeds the range.
               if (type_ff != '0) begin
                  type_in = TYPE_SAT;
               end else if (digit > 4'd3) begin
                  type_in = TYPE_SAT;
               end else begin
                  type_in = digit[TYPE_W-1:0];
               end
               phase_in = PH_TYPE;
            end else if ((ph == PH_TYPE_WS) && is_ws(char_code)) begin
            end else if ((ph == PH_TYPE) && is_ws(char_code)) begin
               phase_in = PH_SEMI_WS;
            end else if ((ph == PH_TYPE) && (char_code == CH_SEMI)) begin
               phase_in = PH_AFTER_SEMI;
            end else begin
               stat_in  = ST_SYNTAX;
               phase_in = PH_DONE;
            end
         end
         PH_SEMI_WS: begin
            if (is_ws(char_code)) begin
            end else if (char_code == CH_SEMI) begin
               phase_in = PH_AFTER_SEMI;
            end else begin
               stat_in  = ST_SYNTAX;
               phase_in = PH_DONE;
            end
         end
         PH_AFTER_SEMI, PH_CR: begin
            if (char_code == CH_LF) begin
               stat_in  = (type_ff > TYPE_MAX) ? ST_TYPE_OOR : ST_ACCEPTED;
               phase_in = PH_DONE;
            end else if ((ph == PH_AFTER_SEMI) && (char_code == CH_CR)) begin
               phase_in = PH_CR;
            end else begin
               stat_in  = ST_SYNTAX;
               phase_in = PH_DONE;
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase

      // The flagged last character closes the line whatever phase it reached.
      if (end_of_text) begin
         if (phase_in == PH_AFTER_SEMI) begin
            stat_in = (type_in > TYPE_MAX) ? ST_TYPE_OOR : ST_ACCEPTED;
         end else if (phase_in == PH_ID_DIG) begin
            stat_in = ovf_in ? ST_ID_OVFL : ST_SYNTAX;
         end else if (phase_in != PH_DONE) begin
            stat_in = ST_SYNTAX;
         end
      end

      verdict_id = ovf_in ? '0 : (neg_in ? ('0 - mag_in) : mag_in);

      push.name_valid              = accept && name_hit;
      push.name_res.kind           = KIND_NAME;
      push.name_res.name_char      = char_code;
      push.name_res.msg_id         = '0;
      push.name_res.value_type     = '0;
      push.name_res.status         = ST_ACCEPTED;
      push.name_res.last_of_run    = !end_of_text;

      push.verdict_valid           = accept && end_of_text;
      push.verdict_res.kind        = KIND_VERDICT;
      push.verdict_res.name_char   = '0;
      push.verdict_res.msg_id      = verdict_id;
      push.verdict_res.value_type  = (stat_in == ST_ACCEPTED) ? type_in : '0;
      push.verdict_res.status      = stat_in;
      push.verdict_res.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && end_of_text)) begin
         phase_ff  <= PH_LEAD;
         kw_idx_ff <= '0;
         neg_ff    <= 1'b0;
         mag_ff    <= '0;
         ovf_ff    <= 1'b0;
         type_ff   <= '0;
         stat_ff   <= ST_ACCEPTED;
      end else if (accept) begin
         phase_ff  <= phase_in;
         kw_idx_ff <= kw_idx_in;
         neg_ff    <= neg_in;
         mag_ff    <= mag_in;
         ovf_ff    <= ovf_in;
         type_ff   <= type_in;
         stat_ff   <= stat_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/svtlp_fifo.sv
`default_nettype none
module svtlp_fifo import svtlp_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   output logic          space,
   output logic          out_valid,
   input  wire logic     out_ready,
   output rsp_item_type  out_item
);

   rsp_item_type          mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]  count_ff, count_in;
   logic [1:0]            push_n;
   logic                  pop;
   logic                  push_any;

   assign push_n    = {1'b0, push.name_valid} + {1'b0, push.verdict_valid};
   assign push_any  = push.name_valid || push.verdict_valid;
   assign out_valid = (count_ff != '0);
   assign pop       = out_valid && out_ready;
   assign out_item  = mem_ff[rd_ptr_ff];
   // Room for the two beats that one character may cause.
   assign space     = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));

   assign wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
   assign count_in  = count_ff + RSP_CNT_W'(push_n) - RSP_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push.name_valid) begin
         mem_ff[wr_ptr_ff] <= push.name_res;
      end
      if (push.verdict_valid) begin
         mem_ff[wr_ptr_ff + RSP_PTR_W'(push.name_valid)] <= push.verdict_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("result queue count beyond depth");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push_any |-> space)
      else $error("result pushed without room for two beats");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (pop && !push_any) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("result queue count not decremented on pop");
`endif

endmodule
`default_nettype wire

FILE: design/signal_value_type_line_parser.sv
`default_nettype none
// Result beats of an accepted character are registered in the result queue first.
// Throughput: one character per cycle while the result queue has room for two beats; a
// character with a name beat and the verdict needs two beats of the single output port.
// Reset: synchronous, active high; clears the parser state and empties the result queue.
// After each verdict the parser returns to its reset state for the next line.
module signal_value_type_line_parser import svtlp_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   svtlp_req_if.sink   req_chan,
   svtlp_rsp_if.source rsp_chan
);

   push_type     push;
   logic         space;
   logic         accept;
   rsp_item_type out_item;

   assign req_chan.ready = space;
   assign accept         = req_chan.valid && space;

   svtlp_core u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .char_code   (req_chan.char_code),
      .end_of_text (req_chan.end_of_text),
      .push        (push)
   );

   svtlp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space     (space),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_item  (out_item)
   );

   assign rsp_chan.kind        = out_item.kind;
   assign rsp_chan.name_char   = out_item.name_char;
   assign rsp_chan.msg_id      = out_item.msg_id;
   assign rsp_chan.value_type  = out_item.value_type;
   assign rsp_chan.status      = out_item.status;
   assign rsp_chan.last_of_run = out_item.last_of_run;

endmodule
`default_nettype wire
